@@ rtl/sfl_pkg.sv @@
// ----------------------------------------------------------------------------
// sfl_pkg
// Shared types and constants of the sorted factor list: list depth, derived
// widths, request and status codes, controller state and command structs.
// ----------------------------------------------------------------------------
package sfl_pkg;

  localparam int unsigned LIST_DEPTH = 32;
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned CNT_W      = $clog2(LIST_DEPTH + 1);
  localparam int unsigned IDX_W      = $clog2(LIST_DEPTH);

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_READ   = 2'd1,
    REQ_CLEAR  = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic    ins;
    logic    clr;
    logic    rd_start;
    logic    rd_step;
    logic    out_load;
    logic    out_from_list;
    status_e out_status;
  } sfl_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic rd_last;
    logic out_free;
  } sfl_sts_t;

endpackage

@@ rtl/sfl_if.sv @@
// ----------------------------------------------------------------------------
// sfl_if
// Request and result channels of the sorted factor list, valid/ready
// handshake with source and sink modports.
// ----------------------------------------------------------------------------
interface sfl_req_if import sfl_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output req_type, output value, input ready);
  modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface sfl_rsp_if import sfl_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] item;
  logic               last;
  logic [1:0]         status;

  modport source (output valid, output item, output last, output status, input ready);
  modport sink   (input valid, input item, input last, input status, output ready);
endinterface

@@ rtl/sfl_datapath.sv @@
// ----------------------------------------------------------------------------
// sfl_datapath
// Row of compare-and-shift cells holding the ascending list, fill count,
// readout index and the result register.
// ----------------------------------------------------------------------------
module sfl_datapath import sfl_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sfl_cmd_t           cmd_i,
  output sfl_sts_t           sts_o,
  input  logic [VALUE_W-1:0] value_i,
  output logic               rsp_valid_o,
  input  logic               rsp_ready_i,
  output logic [VALUE_W-1:0] rsp_item_o,
  output logic               rsp_last_o,
  output logic [1:0]         rsp_status_o
);

  logic [VALUE_W-1:0] entries_q [LIST_DEPTH];
  logic [VALUE_W-1:0] entries_d [LIST_DEPTH];
  logic [LIST_DEPTH-1:0] lt;
  logic [CNT_W-1:0]   fill_q, fill_d;
  logic [IDX_W-1:0]   rd_idx_q, rd_idx_d;
  logic               out_valid_q, out_valid_d;
  logic [VALUE_W-1:0] out_item_q, out_item_d;
  logic               out_last_q, out_last_d;
  status_e            out_status_q, out_status_d;
  logic               rd_last;

  // cell i holds a stored value smaller than the new one
  always_comb begin
    for (int i = 0; i < LIST_DEPTH; i++) begin
      lt[i] = (CNT_W'(i) < fill_q) && (entries_q[i] < value_i);
    end
  end

  // smaller values stay, the rest move up one place, new value lands at the edge
  always_comb begin
    for (int i = 0; i < LIST_DEPTH; i++) begin
      if (lt[i]) begin
        entries_d[i] = entries_q[i];
      end else if (i > 0 && !lt[(i > 0) ? i - 1 : 0]) begin
        entries_d[i] = entries_q[(i > 0) ? i - 1 : 0];
      end else begin
        entries_d[i] = value_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ins) begin
      for (int i = 0; i < LIST_DEPTH; i++) begin
        entries_q[i] <= entries_d[i];
      end
    end
  end

  assign rd_last = ((CNT_W'(rd_idx_q) + CNT_W'(1)) == fill_q);

  always_comb begin
    fill_d = fill_q;
    if (cmd_i.clr) begin
      fill_d = '0;
    end else if (cmd_i.ins) begin
      fill_d = fill_q + CNT_W'(1);
    end
  end

  always_comb begin
    rd_idx_d = rd_idx_q;
    if (cmd_i.rd_start) begin
      rd_idx_d = '0;
    end else if (cmd_i.rd_step) begin
      rd_idx_d = rd_idx_q + IDX_W'(1);
    end
  end

  always_comb begin
    out_valid_d  = out_valid_q && !rsp_ready_i;
    out_item_d   = out_item_q;
    out_last_d   = out_last_q;
    out_status_d = out_status_q;
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
      if (cmd_i.out_from_list) begin
        out_item_d   = entries_q[rd_idx_q];
        out_last_d   = rd_last;
        out_status_d = STATUS_OK;
      end else begin
        out_item_d   = '0;
        out_last_d   = 1'b1;
        out_status_d = cmd_i.out_status;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      rd_idx_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q      <= fill_d;
      rd_idx_q    <= rd_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_item_q   <= out_item_d;
    out_last_q   <= out_last_d;
    out_status_q <= out_status_d;
  end

  assign sts_o.full     = (fill_q == CNT_W'(LIST_DEPTH));
  assign sts_o.empty    = (fill_q == '0);
  assign sts_o.rd_last  = rd_last;
  assign sts_o.out_free = !out_valid_q || rsp_ready_i;

  assign rsp_valid_o  = out_valid_q;
  assign rsp_item_o   = out_item_q;
  assign rsp_last_o   = out_last_q;
  assign rsp_status_o = out_status_q;

endmodule

@@ rtl/sfl_ctrl.sv @@
// ----------------------------------------------------------------------------
// sfl_ctrl
// Request decoder and readout sequencer of the sorted factor list.
// ----------------------------------------------------------------------------
module sfl_ctrl import sfl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       req_valid_i,
  output logic       req_ready_o,
  input  logic [1:0] req_type_i,
  input  sfl_sts_t   sts_i,
  output sfl_cmd_t   cmd_o
);

  state_e state_q, state_d;
  req_e   req_type;
  logic   accept;

  assign req_type    = req_e'(req_type_i);
  assign req_ready_o = (state_q == ST_IDLE) && sts_i.out_free;
  assign accept      = req_valid_i && req_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.out_status = STATUS_OK;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (req_type)
            REQ_INSERT: begin
              cmd_o.ins        = !sts_i.full;
              cmd_o.out_load   = 1'b1;
              cmd_o.out_status = sts_i.full ? STATUS_FULL : STATUS_OK;
            end
            REQ_READ: begin
              if (sts_i.empty) begin
                cmd_o.out_load   = 1'b1;
                cmd_o.out_status = STATUS_EMPTY;
              end else begin
                cmd_o.rd_start = 1'b1;
                state_d        = ST_READ;
              end
            end
            REQ_CLEAR: begin
              cmd_o.clr      = 1'b1;
              cmd_o.out_load = 1'b1;
            end
            default: begin
              // unused request code: no result
            end
          endcase
        end
      end
      ST_READ: begin
        if (sts_i.out_free) begin
          cmd_o.out_load      = 1'b1;
          cmd_o.out_from_list = 1'b1;
          cmd_o.rd_step       = 1'b1;
          if (sts_i.rd_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/sorted_factor_list.sv @@
// ----------------------------------------------------------------------------
// sorted_factor_list
// Bounded ascending list of 32-bit values with insert, readout and clear.
// ----------------------------------------------------------------------------
// The row of compare-and-shift cells places an inserted value in the same edge
// that accepts it; an insert or a clear loads its single status result into
// the result register, and an unused request code gives no result. A readout
// sends the stored values through one read port, one value per cycle while
// the result register is free, and the next request is taken after the final
// value is loaded. A full result register that is not taken stalls requests.
module sorted_factor_list import sfl_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  sfl_req_if.sink          req_i,
  sfl_rsp_if.source        rsp_o
);

  sfl_cmd_t cmd;
  sfl_sts_t sts;

  sfl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .req_type_i  (req_i.req_type),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  sfl_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .value_i      (req_i.value),
    .rsp_valid_o  (rsp_o.valid),
    .rsp_ready_i  (rsp_o.ready),
    .rsp_item_o   (rsp_o.item),
    .rsp_last_o   (rsp_o.last),
    .rsp_status_o (rsp_o.status)
  );

endmodule
